// ===== hw/rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants of the prime sieve counter
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int LIMIT_W     = 17;
  localparam int COUNT_W     = 13;
  localparam int FIRST_PRIME = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_COUNT,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // sequencer to tally control
  typedef struct packed {
    logic clear;   // new request, restart the count
    logic issue;   // mark read issued this cycle, data next cycle
  } tally_ctl_t;

endpackage

// ===== hw/rtl/prime_sieve_counter.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_counter
// counts the primes below a limit with a sieve over a one-bit mark table
// ----------------------------------------------------------------------------
// passes: fill writes marks 0..n, n = min(limit, MAX_LIMIT); sieve probes each
//   value whose square is at most n and clears its multiples from the square up;
//   count reads marks below n; then a drain and a done state
// throughput: one request at a time, next start transfer taken in the cycle after
//   the result strobe; the result cannot be stalled
// reset: synchronous, active low, sequencer to idle; table rewritten per request
module prime_sieve_counter import psc_pkg::*; #(
  parameter int MAX_LIMIT = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [LIMIT_W-1:0] in_limit,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_prime_count
);

  // table holds entries 0..MAX_LIMIT so the sieve may touch index n
  localparam int DEPTH = MAX_LIMIT + 1;
  localparam int AW    = $clog2(DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          rd_data;
  tally_ctl_t    ctl;
  logic          done;
  logic [COUNT_W-1:0] count;

  // sequencer: saturates the limit, then walks fill, sieve and count passes
  psc_seq #(
    .MAX_LIMIT (MAX_LIMIT),
    .AW        (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .limit   (in_limit),
    .busy    (busy),
    .done    (done),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .ctl     (ctl)
  );

  // mark table, read data registered and valid in the cycle after the address
  psc_mark_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // running count of surviving marks below n
  psc_tally u_tally (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (rd_data),
    .count_r (count)
  );

  // result transfer: one-cycle strobe in the done state
  assign out_valid       = done;
  assign out_prime_count = count;

endmodule

// ===== hw/rtl/psc_mark_ram.sv =====
// ----------------------------------------------------------------------------
// psc_mark_ram
// one-bit-per-number mark table, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module psc_mark_ram #(
  parameter int DEPTH = 65537,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data_r
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/psc_tally.sv =====
// ----------------------------------------------------------------------------
// psc_tally
// counts set marks returned by the table, saturating at the field maximum
// ----------------------------------------------------------------------------
module psc_tally import psc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tally_ctl_t         ctl,
  input  logic               rd_data,
  output logic [COUNT_W-1:0] count_r
);

  logic               sample_r;
  logic               sample_nxt;
  logic [COUNT_W-1:0] count_nxt;

  always_comb begin
    sample_nxt = ctl.issue;
    count_nxt  = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (sample_r && rd_data && (count_r != COUNT_MAX)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= 1'b0;
      count_r  <= '0;
    end else begin
      sample_r <= sample_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/psc_seq.sv =====
// ----------------------------------------------------------------------------
// psc_seq
// sequencer: fill, sieve and count passes over the mark table
// ----------------------------------------------------------------------------
module psc_seq import psc_pkg::*; #(
  parameter int MAX_LIMIT = 65536,
  parameter int AW        = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [LIMIT_W-1:0] limit,
  output logic               busy,
  output logic               done,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic               wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic               rd_data,
  output tally_ctl_t         ctl
);

  localparam int SW = AW + 1;
  localparam int CW = (AW > LIMIT_W) ? AW : LIMIT_W;
  localparam logic [SW-1:0] FIRST_SQ = SW'(FIRST_PRIME * FIRST_PRIME);

  state_t        state_r, state_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic [AW-1:0] j_r, j_nxt;

  logic          accept;
  logic [AW-1:0] n_sat;
  logic [SW-1:0] j_step;
  logic [SW-1:0] sq_step;
  logic          clear_end;
  logic          sieve_end;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    if (CW'(limit) > CW'(MAX_LIMIT)) begin
      n_sat = AW'(MAX_LIMIT);
    end else begin
      n_sat = AW'(limit);
    end
  end

  assign j_step    = SW'(j_r) + SW'(i_r);
  assign sq_step   = sq_r + {i_r, 1'b1};
  assign clear_end = j_step > SW'(n_r);
  assign sieve_end = sq_step > SW'(n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (a_r == n_r) begin
          state_nxt = (FIRST_SQ > SW'(n_r)) ? ST_COUNT : ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (rd_data)        state_nxt = ST_CLEAR;
        else if (sieve_end) state_nxt = ST_COUNT;
        else                state_nxt = ST_READ;
      end
      ST_CLEAR: begin
        if (clear_end) state_nxt = sieve_end ? ST_COUNT : ST_READ;
      end
      ST_COUNT: begin
        if (a_r == n_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    done      = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = a_r;
    wr_data   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = a_r;
    ctl.clear = accept;
    ctl.issue = 1'b0;
    case (state_r)
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_data = (a_r >= AW'(FIRST_PRIME));
      end
      ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = i_r;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
      end
      ST_COUNT: begin
        if (a_r != n_r) begin
          rd_en     = 1'b1;
          ctl.issue = 1'b1;
        end
      end
      ST_DONE:  done = 1'b1;
      default: ;
    endcase
  end

  // address and loop counters
  always_comb begin
    n_nxt  = n_r;
    a_nxt  = a_r;
    i_nxt  = i_r;
    sq_nxt = sq_r;
    j_nxt  = j_r;
    case (state_r)
      ST_IDLE: begin
        n_nxt = n_sat;
        a_nxt = '0;
      end
      ST_FILL: begin
        if (a_r == n_r) begin
          a_nxt  = '0;
          i_nxt  = AW'(FIRST_PRIME);
          sq_nxt = FIRST_SQ;
        end else begin
          a_nxt = a_r + 1'b1;
        end
      end
      ST_CHECK: begin
        if (rd_data) begin
          j_nxt = AW'(sq_r);
        end else begin
          i_nxt  = i_r + 1'b1;
          sq_nxt = sq_step;
        end
      end
      ST_CLEAR: begin
        if (clear_end) begin
          i_nxt  = i_r + 1'b1;
          sq_nxt = sq_step;
        end else begin
          j_nxt = AW'(j_step);
        end
      end
      ST_COUNT: begin
        if (a_r != n_r) a_nxt = a_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r  <= n_nxt;
    a_r  <= a_nxt;
    i_r  <= i_nxt;
    sq_r <= sq_nxt;
    j_r  <= j_nxt;
  end

endmodule

// ===== tb/sv/tb_prime_sieve_counter.sv =====
// ----------------------------------------------------------------------------
// tb_prime_sieve_counter
// self-checking bench for the prime sieve counter: a short table of limits
// (edges, small primes, the saturating range) followed by mostly small random
// limits, each result compared against a typed-in count or a sieve kept inside the bench
// ----------------------------------------------------------------------------
module tb_prime_sieve_counter;
  import psc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LIMIT     = 65536;
  localparam int RANDOM_ITEMS  = 100;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = 20;

  // one row of directed stimulus; known marks a count that is typed in
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               known;
    logic [COUNT_W-1:0] count;
  } limit_row_t;

  localparam int DIRECTED_ROWS = 15;
  localparam limit_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{17'd0,      1'b1, 13'd0},     // empty range
    '{17'd1,      1'b1, 13'd0},     // only zero below
    '{17'd2,      1'b1, 13'd0},     // two itself is excluded
    '{17'd3,      1'b1, 13'd1},     // first prime counted
    '{17'd4,      1'b0, 13'd0},
    '{17'd5,      1'b0, 13'd0},
    '{17'd11,     1'b0, 13'd0},     // prime at the limit, not counted
    '{17'd12,     1'b0, 13'd0},
    '{17'd97,     1'b0, 13'd0},
    '{17'd100,    1'b0, 13'd0},
    '{17'd1000,   1'b0, 13'd0},
    '{17'd1024,   1'b0, 13'd0},
    '{17'd8191,   1'b0, 13'd0},
    '{17'd65536,  1'b1, 13'd6542},  // full table
    '{17'd131071, 1'b1, 13'd6542}   // above the table, saturates
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [LIMIT_W-1:0] in_limit;
  logic               out_valid;
  logic [COUNT_W-1:0] out_prime_count;

  // typed-in count travelling with the request, sampled at the transfer
  logic               req_known;
  logic [COUNT_W-1:0] req_count;

  logic [COUNT_W-1:0] pending_counts[$];
  int unsigned        errors;
  int unsigned        cycles;
  bit                 burst_mode;

  // scratch marks of the bench's own sieve, one bit per number
  bit                 sieve_marks [0:MAX_LIMIT];

  prime_sieve_counter #(
    .MAX_LIMIT(MAX_LIMIT)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_limit       (in_limit),
    .out_valid      (out_valid),
    .out_prime_count(out_prime_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // primes strictly below the limit; the limit is clamped to the table size
  // and the count clamps to the widest value the port can carry
  function automatic logic [COUNT_W-1:0] primes_below(input logic [LIMIT_W-1:0] limit);
    longint n;
    longint i;
    longint j;
    longint total;
    n = limit;
    total = 0;
    if (n > MAX_LIMIT) n = MAX_LIMIT;
    for (i = 0; i <= n; i++) sieve_marks[i] = 1'b1;
    sieve_marks[0] = 1'b0;
    sieve_marks[1] = 1'b0;
    for (i = FIRST_PRIME; i <= n; i++) begin
      if (sieve_marks[i]) begin
        for (j = i * i; j <= n; j += i) sieve_marks[j] = 1'b0;
      end
    end
    for (i = 0; i < n; i++) begin
      if (sieve_marks[i]) total++;
    end
    if (total > COUNT_MAX) total = COUNT_MAX;
    return total[COUNT_W-1:0];
  endfunction

  // watchdog: a hung block or a lost strobe ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding",
               cycles, pending_counts.size());
      $display("** prime_sieve_counter: FAILED **");
      $finish;
    end
  end

  // result check first, then record the expectation of a new transfer;
  // everything is sampled before the edge takes effect
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_counts.size() == 0) begin
          $display("%0t: unexpected result, prime_count %0d", $time, out_prime_count);
          errors++;
        end else begin
          if (out_prime_count !== pending_counts[0]) begin
            $display("%0t: prime_count mismatch, expected %0d, actual %0d",
                     $time, pending_counts[0], out_prime_count);
            errors++;
          end
          void'(pending_counts.pop_front());
        end
      end
      if (start && !busy) begin
        if (req_known) pending_counts.insert(pending_counts.size(), req_count);
        else pending_counts.insert(pending_counts.size(), primes_below(in_limit));
      end
    end
  end

  // one request transfer; called and returning just after a falling edge.
  // a zero gap keeps start high straight into the next request
  task automatic send_limit(input logic [LIMIT_W-1:0] limit, input logic known,
                            input logic [COUNT_W-1:0] count);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    in_limit  <= limit;
    req_known <= known;
    req_count <= count;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every outstanding count has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending_counts.size() != 0) @(negedge clk);
  endtask

  // mostly tiny limits, some mid-size, a few that fill several thousand marks
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return LIMIT_W'($urandom_range(0, 63));
    else if (r < 92) return LIMIT_W'($urandom_range(64, 1023));
    else return LIMIT_W'($urandom_range(1024, 8191));
  endfunction

  initial begin
    errors     = 0;
    cycles     = 0;
    burst_mode = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_limit   = '0;
    req_known  = 1'b0;
    req_count  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    foreach (DIRECTED[k]) begin
      send_limit(DIRECTED[k].limit, DIRECTED[k].known, DIRECTED[k].count);
    end
    wait_drained();

    // random part; bursts of back-to-back requests alternate with gappy runs
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 12 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (k % 25 == 24) wait_drained();
      send_limit(pick_limit(), 1'b0, '0);
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_counts.size() != 0) begin
      $display("%0t: %0d counts never arrived", $time, pending_counts.size());
      errors++;
    end

    if (errors == 0) begin
      $display("** prime_sieve_counter: PASSED **");
    end else begin
      $display("** prime_sieve_counter: FAILED **");
    end
    $finish;
  end

endmodule
